// ----- rtl/core/rha_pkg.sv -----
// ----------------------------------------------------------------------------
// rha_pkg: shared types and constants of the RBM hidden activation core
// Item layouts, table geometry, the chain link and the sigmoid table.
// ----------------------------------------------------------------------------
package rha_pkg;

  localparam int VOCAB_MAX  = 1024;
  localparam int DIM_MAX    = 32;
  localparam int HIDDEN_MAX = 64;
  localparam int NGRAM_MAX  = 8;

  localparam int WORD_W   = $clog2(VOCAB_MAX);
  localparam int DIM_W    = $clog2(DIM_MAX);
  localparam int HID_W    = $clog2(HIDDEN_MAX);
  localparam int POS_W    = $clog2(NGRAM_MAX);
  localparam int EMB_AW   = WORD_W + DIM_W;
  localparam int WGT_AW   = POS_W + DIM_W;
  localparam int ACC_W    = 40;
  localparam int VAL_W    = 16;
  localparam int PROD_W   = 2 * VAL_W;

  typedef enum logic [1:0] {
    REQ_LOAD_EMB  = 2'd0,
    REQ_LOAD_WGT  = 2'd1,
    REQ_LOAD_BIAS = 2'd2,
    REQ_CONTEXT   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_NGRAM_LEN    = 2'd0,
    CFG_HIDDEN_COUNT = 2'd1,
    CFG_EMBED_DIM    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_FLUSH,
    ST_BIAS_RD,
    ST_ACT_CALC,
    ST_SIG_MUL,
    ST_SIG_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [14:0]        table_address;
    logic signed [15:0] load_value;
    logic [9:0]         word_id;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         hidden_index;
    logic signed [23:0] activation;
    logic [15:0]        probability;
    logic               last_of_run;
  } out_item_t;

  // One embedding element travelling down the row of cells.
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] e;
    logic [WGT_AW-1:0]       waddr;
  } cell_link_t;

  // Weight write port of one cell.
  typedef struct packed {
    logic              we;
    logic [WGT_AW-1:0] addr;
    logic [VAL_W-1:0]  data;
  } cell_wr_t;

  // Sigmoid at steps of 0.25 over 0..8, Q0.16.
  function automatic logic [15:0] sig_lut(input logic [5:0] k);
    logic [15:0] v;
    unique case (k)
      6'd0:  v = 16'd32768; 6'd1:  v = 16'd36843; 6'd2:  v = 16'd40793;
      6'd3:  v = 16'd44511; 6'd4:  v = 16'd47910; 6'd5:  v = 16'd50941;
      6'd6:  v = 16'd53581; 6'd7:  v = 16'd55834; 6'd8:  v = 16'd57724;
      6'd9:  v = 16'd59287; 6'd10: v = 16'd60565; 6'd11: v = 16'd61598;
      6'd12: v = 16'd62428; 6'd13: v = 16'd63090; 6'd14: v = 16'd63615;
      6'd15: v = 16'd64030; 6'd16: v = 16'd64357; 6'd17: v = 16'd64614;
      6'd18: v = 16'd64816; 6'd19: v = 16'd64974; 6'd20: v = 16'd65097;
      6'd21: v = 16'd65194; 6'd22: v = 16'd65269; 6'd23: v = 16'd65328;
      6'd24: v = 16'd65374; 6'd25: v = 16'd65410; 6'd26: v = 16'd65438;
      6'd27: v = 16'd65459; 6'd28: v = 16'd65476; 6'd29: v = 16'd65489;
      6'd30: v = 16'd65500; 6'd31: v = 16'd65508;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/rha_ram.sv -----
// ----------------------------------------------------------------------------
// rha_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/rha_cell.sv -----
// ----------------------------------------------------------------------------
// rha_cell: one hidden unit of the chain
// Holds the unit's weights and accumulator, multiplies each passing
// embedding element by its weight and hands the element to the next cell.
// ----------------------------------------------------------------------------
module rha_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic                                active,
  input  rha_pkg::cell_wr_t                   wr,
  input  rha_pkg::cell_link_t                 link_in,
  output rha_pkg::cell_link_t                 link_out,
  input  logic                                shift_en,
  input  logic signed [rha_pkg::ACC_W-1:0]    acc_in,
  output logic signed [rha_pkg::ACC_W-1:0]    acc_out
);

  localparam logic signed [rha_pkg::ACC_W-1:0] ACC_HI = {1'b0, {(rha_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [rha_pkg::ACC_W-1:0] ACC_LO = {1'b1, {(rha_pkg::ACC_W-1){1'b0}}};

  rha_pkg::cell_link_t                 link_q;
  logic [rha_pkg::VAL_W-1:0]           w_rdata;
  logic                                prod_valid;
  logic signed [rha_pkg::PROD_W-1:0]   prod;
  logic signed [rha_pkg::ACC_W-1:0]    acc;
  logic signed [rha_pkg::ACC_W:0]      acc_sum;

  rha_ram #(
    .WIDTH(rha_pkg::VAL_W),
    .DEPTH(rha_pkg::NGRAM_MAX * rha_pkg::DIM_MAX)
  ) u_wgt (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.addr),
    .wdata(wr.data),
    .raddr(link_in.waddr),
    .rdata(w_rdata)
  );

  // Hand the element on; the weight read data is registered in step with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_q.valid <= 1'b0;
      prod_valid   <= 1'b0;
    end else begin
      link_q.valid <= link_in.valid;
      prod_valid   <= link_q.valid & active;
    end
    link_q.e     <= link_in.e;
    link_q.waddr <= link_in.waddr;
    prod         <= link_q.e * $signed(w_rdata);
  end

  assign link_out = link_q;

  assign acc_sum = {acc[rha_pkg::ACC_W-1], acc}
                 + (rha_pkg::ACC_W+1)'(prod);

  // Saturate after every product.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
    end else if (shift_en) begin
      acc <= acc_in;
    end else if (prod_valid) begin
      if (acc_sum[rha_pkg::ACC_W] != acc_sum[rha_pkg::ACC_W-1]) begin
        acc <= acc_sum[rha_pkg::ACC_W] ? ACC_LO : ACC_HI;
      end else begin
        acc <= acc_sum[rha_pkg::ACC_W-1:0];
      end
    end
  end

  assign acc_out = acc;

endmodule

// ----- rtl/core/rbm_hidden_activation.sv -----
// ----------------------------------------------------------------------------
// rbm_hidden_activation_core: RBM hidden-unit activations and probabilities
// Row of 64 hidden-unit cells fed with one embedding element per cycle.
// ----------------------------------------------------------------------------
// Load items write the embedding RAM, the weight RAM of one cell, or the
// bias RAM. A context word streams its embed_dim embedding elements, one
// per cycle, into a row of 64 cells; each cell multiplies the element by
// its weight for the current position, adds it to its own 40-bit
// saturating accumulator if the cell is active, and passes the element to
// the next cell. A context word therefore occupies the block for the
// element stream plus the trip down the row of cells. After the last
// word of an n-gram the accumulators shift out through cell 0 one unit
// at a time; each result passes through bias read, rounding and
// sigmoid interpolation, plus any wait on out_ready. The shift leaves the
// accumulators cleared. The block takes one item at a time: in_ready is low
// while a word or a drain is in progress. A configuration write drops any
// partial n-gram.
// ----------------------------------------------------------------------------
module rbm_hidden_activation_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rha_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rha_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int FLUSH_LEN = rha_pkg::HIDDEN_MAX + 8;
  localparam int FLUSH_W   = $clog2(FLUSH_LEN);

  rha_pkg::state_t state, state_next;

  // Configuration registers and their clamped working values
  logic [3:0] ngram_len;
  logic [6:0] hidden_count;
  logic [5:0] embed_dim;
  logic [3:0] nl_eff;
  logic [6:0] hc_eff;
  logic [5:0] ed_eff;
  logic       cfg_hit;

  // Sequencer
  logic [rha_pkg::WORD_W-1:0] word;
  logic [rha_pkg::POS_W-1:0]  pos_cnt;
  logic [rha_pkg::DIM_W-1:0]  d_cnt;
  logic [FLUSH_W-1:0]         flush_cnt;
  logic [rha_pkg::HID_W-1:0]  h_cnt;
  logic                       in_fire, out_fire;
  logic                       feed_last, flush_last, run_last, unit_last;
  logic                       shift_en;

  // Feed into cell 0
  logic                             feed_v;
  logic [rha_pkg::WGT_AW-1:0]       feed_addr;
  logic [rha_pkg::VAL_W-1:0]        emb_rdata;
  logic                             emb_we;
  logic [rha_pkg::VAL_W-1:0]        bias_rdata;
  logic                             bias_we;
  logic                             wgt_we;

  rha_pkg::cell_link_t              link [rha_pkg::HIDDEN_MAX+1];
  logic signed [rha_pkg::ACC_W-1:0] acc_link [rha_pkg::HIDDEN_MAX+1];

  // Post-processing registers
  logic signed [23:0] act;
  logic               sig_big, sig_neg;
  logic [15:0]        sig_base;
  logic [25:0]        sig_prod;
  logic signed [rha_pkg::ACC_W:0] act_sum;
  logic signed [28:0] act_wide;
  logic [24:0]        mag;
  logic [14:0]        kidx;
  logic [15:0]        t_lo, t_hi;
  logic [16:0]        p_pos, p_out;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_hit = cfg_we && (cfg_index != rha_pkg::CFG_UNUSED);

  always_ff @(posedge clk) begin
    if (rst) begin
      ngram_len    <= 4'd4;
      hidden_count <= 7'd64;
      embed_dim    <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rha_pkg::CFG_NGRAM_LEN:    ngram_len    <= cfg_data[3:0];
        rha_pkg::CFG_HIDDEN_COUNT: hidden_count <= cfg_data;
        rha_pkg::CFG_EMBED_DIM:    embed_dim    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; above the maximum acts as the maximum.
  always_comb begin
    if (ngram_len == 4'd0) nl_eff = 4'd1;
    else if (ngram_len > 4'(rha_pkg::NGRAM_MAX)) nl_eff = 4'(rha_pkg::NGRAM_MAX);
    else nl_eff = ngram_len;
    if (hidden_count == 7'd0) hc_eff = 7'd1;
    else if (hidden_count > 7'(rha_pkg::HIDDEN_MAX)) hc_eff = 7'(rha_pkg::HIDDEN_MAX);
    else hc_eff = hidden_count;
    if (embed_dim == 6'd0) ed_eff = 6'd1;
    else if (embed_dim > 6'(rha_pkg::DIM_MAX)) ed_eff = 6'(rha_pkg::DIM_MAX);
    else ed_eff = embed_dim;
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign feed_last  = {1'b0, d_cnt} == 6'(ed_eff - 6'd1);
  assign flush_last = flush_cnt == FLUSH_W'(FLUSH_LEN - 1);
  assign run_last   = 4'({1'b0, pos_cnt} + 4'd1) == nl_eff;
  assign unit_last  = {1'b0, h_cnt} == 7'(hc_eff - 7'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      rha_pkg::ST_IDLE: begin
        if (in_fire && in_item.req_type == rha_pkg::REQ_CONTEXT) begin
          state_next = rha_pkg::ST_FEED;
        end
      end
      rha_pkg::ST_FEED: begin
        if (feed_last) state_next = rha_pkg::ST_FLUSH;
      end
      rha_pkg::ST_FLUSH: begin
        if (flush_last) begin
          state_next = run_last ? rha_pkg::ST_BIAS_RD : rha_pkg::ST_IDLE;
        end
      end
      rha_pkg::ST_BIAS_RD:  state_next = rha_pkg::ST_ACT_CALC;
      rha_pkg::ST_ACT_CALC: state_next = rha_pkg::ST_SIG_MUL;
      rha_pkg::ST_SIG_MUL:  state_next = rha_pkg::ST_SIG_ADD;
      rha_pkg::ST_SIG_ADD:  state_next = rha_pkg::ST_EMIT;
      rha_pkg::ST_EMIT: begin
        if (out_ready) begin
          state_next = unit_last ? rha_pkg::ST_IDLE : rha_pkg::ST_BIAS_RD;
        end
      end
      default: state_next = rha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == rha_pkg::ST_IDLE);
    out_valid = (state == rha_pkg::ST_EMIT);
    shift_en  = (state == rha_pkg::ST_EMIT) && out_ready;
    emb_we    = in_fire && in_item.req_type == rha_pkg::REQ_LOAD_EMB;
    wgt_we    = in_fire && in_item.req_type == rha_pkg::REQ_LOAD_WGT
                && !in_item.table_address[14];
    bias_we   = in_fire && in_item.req_type == rha_pkg::REQ_LOAD_BIAS
                && in_item.table_address[14:6] == 9'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rha_pkg::ST_IDLE;
      pos_cnt   <= '0;
      d_cnt     <= '0;
      flush_cnt <= '0;
      h_cnt     <= '0;
      feed_v    <= 1'b0;
    end else begin
      state  <= state_next;
      feed_v <= (state == rha_pkg::ST_FEED);
      if (cfg_hit) begin
        pos_cnt <= '0;
      end
      // Advance through the embedding elements, then wait out the row.
      if (state == rha_pkg::ST_FEED) begin
        d_cnt <= feed_last ? '0 : d_cnt + 1'b1;
      end
      if (state == rha_pkg::ST_FLUSH) begin
        flush_cnt <= flush_last ? '0 : flush_cnt + 1'b1;
        if (flush_last) begin
          pos_cnt <= run_last ? '0 : pos_cnt + 1'b1;
          h_cnt   <= '0;
        end
      end
      if (out_fire) begin
        h_cnt <= h_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word <= in_item.word_id;
    end
    feed_addr <= {pos_cnt, d_cnt};
  end

  // --------------------------------------------------------------------------
  // Tables
  // --------------------------------------------------------------------------
  rha_ram #(
    .WIDTH(rha_pkg::VAL_W),
    .DEPTH(rha_pkg::VOCAB_MAX * rha_pkg::DIM_MAX)
  ) u_emb (
    .clk  (clk),
    .we   (emb_we),
    .waddr(in_item.table_address),
    .wdata(in_item.load_value),
    .raddr({word, d_cnt}),
    .rdata(emb_rdata)
  );

  rha_ram #(
    .WIDTH(rha_pkg::VAL_W),
    .DEPTH(rha_pkg::HIDDEN_MAX)
  ) u_bias (
    .clk  (clk),
    .we   (bias_we),
    .waddr(in_item.table_address[rha_pkg::HID_W-1:0]),
    .wdata(in_item.load_value),
    .raddr(h_cnt),
    .rdata(bias_rdata)
  );

  // --------------------------------------------------------------------------
  // Row of cells
  // --------------------------------------------------------------------------
  assign link[0].valid = feed_v;
  assign link[0].e     = $signed(emb_rdata);
  assign link[0].waddr = feed_addr;
  assign acc_link[rha_pkg::HIDDEN_MAX] = '0;

  for (genvar h = 0; h < rha_pkg::HIDDEN_MAX; h++) begin : g_cell
    rha_pkg::cell_wr_t wr;
    logic              active;

    assign active  = 7'(h) < hc_eff;
    assign wr.we   = wgt_we && in_item.table_address[10:5] == 6'(h);
    assign wr.addr = {in_item.table_address[13:11], in_item.table_address[4:0]};
    assign wr.data = in_item.load_value;

    rha_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (cfg_hit),
      .active  (active),
      .wr      (wr),
      .link_in (link[h]),
      .link_out(link[h+1]),
      .shift_en(shift_en),
      .acc_in  (acc_link[h+1]),
      .acc_out (acc_link[h])
    );
  end

  // --------------------------------------------------------------------------
  // Activation and sigmoid on the unit at cell 0
  // --------------------------------------------------------------------------
  // Round half up, floor shift by 12, saturate to 24 bits.
  assign act_sum = $signed({{(rha_pkg::ACC_W-27){bias_rdata[15]}}, bias_rdata, 12'd0})
                 + {acc_link[0][rha_pkg::ACC_W-1], acc_link[0]}
                 + (rha_pkg::ACC_W+1)'(2048);
  assign act_wide = act_sum[rha_pkg::ACC_W:12];

  assign mag  = act[23] ? 25'(-{act[23], act}) : {1'b0, act};
  assign kidx = mag[24:10];
  assign t_lo = rha_pkg::sig_lut({1'b0, kidx[4:0]});
  assign t_hi = rha_pkg::sig_lut(6'({1'b0, kidx[4:0]} + 6'd1));

  assign p_pos = sig_big ? 17'(rha_pkg::sig_lut(6'd32))
                         : 17'(sig_base) + 17'((sig_prod + 26'd512) >> 10);
  assign p_out = sig_neg ? 17'(17'h10000 - p_pos) : p_pos;

  always_ff @(posedge clk) begin
    if (state == rha_pkg::ST_ACT_CALC) begin
      if (act_wide > 29'sd8388607) act <= 24'sh7FFFFF;
      else if (act_wide < -29'sd8388608) act <= 24'sh800000;
      else act <= act_wide[23:0];
    end
    if (state == rha_pkg::ST_SIG_MUL) begin
      sig_big  <= |kidx[14:5];
      sig_neg  <= act[23];
      sig_base <= t_lo;
      sig_prod <= 26'(t_hi - t_lo) * 26'(mag[9:0]);
    end
    if (state == rha_pkg::ST_SIG_ADD) begin
      out_item.hidden_index <= h_cnt;
      out_item.activation   <= act;
      out_item.probability  <= p_out[15:0];
      out_item.last_of_run  <= unit_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_item.hidden_index} < hc_eff))
    else $error("result for an inactive hidden unit");

  a_word_starts_feed: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.req_type == rha_pkg::REQ_CONTEXT) |=> state == rha_pkg::ST_FEED)
    else $error("context word did not start the element stream");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_item.last_of_run) |=> in_ready)
    else $error("block not idle after the last result");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rbm_hidden_activation_core
// Drives load and context items through a valid/ready channel, mirrors the
// tables, accumulators and registers in a behavioral predictor, and checks
// every hidden-unit result, in order, against the predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import rha_pkg::*;

  localparam int IDLE_PCT = 9;        // percent idle per out cycle, per offer
  localparam int SETTLE   = 200;      // wait after drain for a word in flight
  localparam int LIMIT    = 3000000;  // hard stop for a hung run
  localparam int EMB_N    = VOCAB_MAX * DIM_MAX;
  localparam int WGT_N    = NGRAM_MAX * HIDDEN_MAX * DIM_MAX;
  localparam longint ACC_TOP = 64'sd549755813887;
  localparam longint ACC_BOT = -ACC_TOP - 1;

  // Sigmoid sample points at steps of 0.25 over 0..8, Q0.16.
  localparam int unsigned SIG_PTS [0:32] = '{
    32768, 36843, 40793, 44511, 47910, 50941, 53581, 55834,
    57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
    64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
    65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
    65514
  };

  // Every input is known from time zero; reset holds until the sequence runs.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       out_ready = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_NGRAM_LEN;
  logic [6:0] cfg_data = '0;
  in_item_t   in_item = '0;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_item;

  always #1 clk = ~clk;

  rbm_hidden_activation_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: shadow tables with written flags, so that the stimulus
  // never lets the block read an entry that was never loaded.
  // --------------------------------------------------------------------------
  logic signed [15:0] emb_mem  [EMB_N];
  bit                 emb_set  [EMB_N];
  logic signed [15:0] wgt_mem  [WGT_N];
  bit                 wgt_set  [WGT_N];
  logic signed [15:0] bias_mem [HIDDEN_MAX];
  bit                 bias_set [HIDDEN_MAX];
  longint             unit_acc [HIDDEN_MAX];
  int                 word_pos;
  logic [6:0]         reg_val  [3];

  out_item_t unit_results [$];   // predicted hidden-unit results, oldest first
  int        errors = 0;
  bit        calm = 1'b0;        // when set, neither side idles
  int        word_pool [8];
  longint    cycles = 0;

  typedef struct packed {
    in_item_t  it;
    bit        fixed;   // use the typed result below instead of the prediction
    out_item_t want;
  } probe_t;

  // Directed rows, run with one word, one unit and one dimension per n-gram.
  localparam probe_t PROBES [0:19] = '{
    '{'{REQ_LOAD_EMB,  15'd0,     16'sh0000, 10'd0},    1'b0, '0},
    '{'{REQ_LOAD_WGT,  15'd0,     16'sh0000, 10'd0},    1'b0, '0},
    '{'{REQ_LOAD_BIAS, 15'd0,     16'sh0000, 10'd0},    1'b0, '0},
    '{'{REQ_CONTEXT,   15'd0,     16'sh0000, 10'd0},    1'b1,
      '{6'd0, 24'sd0, 16'd32768, 1'b1}},
    '{'{REQ_LOAD_BIAS, 15'd0,     16'sh7FFF, 10'd0},    1'b0, '0},
    '{'{REQ_CONTEXT,   15'd0,     16'sh0000, 10'd0},    1'b1,
      '{6'd0, 24'sd32767, 16'd65514, 1'b1}},
    '{'{REQ_LOAD_BIAS, 15'd0,     16'sh8000, 10'd0},    1'b0, '0},
    '{'{REQ_CONTEXT,   15'd0,     16'sh0000, 10'd0},    1'b1,
      '{6'd0, -24'sd32768, 16'd22, 1'b1}},
    '{'{REQ_LOAD_EMB,  15'd0,     16'sh7FFF, 10'd0},    1'b0, '0},
    '{'{REQ_LOAD_WGT,  15'd0,     16'sh8000, 10'd0},    1'b0, '0},
    '{'{REQ_CONTEXT,   15'd0,     16'sh0000, 10'd0},    1'b0, '0},
    '{'{REQ_LOAD_EMB,  15'd32736, 16'sh8000, 10'd0},    1'b0, '0},
    '{'{REQ_LOAD_BIAS, 15'd0,     16'sh0123, 10'd0},    1'b0, '0},
    '{'{REQ_CONTEXT,   15'd32767, 16'shFFFF, 10'd1023}, 1'b0, '0},
    '{'{REQ_LOAD_WGT,  15'd16384, 16'sh1234, 10'd0},    1'b0, '0},
    '{'{REQ_LOAD_WGT,  15'd32767, 16'sh4321, 10'd0},    1'b0, '0},
    '{'{REQ_LOAD_BIAS, 15'd64,    16'sh7FFF, 10'd0},    1'b0, '0},
    '{'{REQ_LOAD_BIAS, 15'd32767, 16'sh8000, 10'd1023}, 1'b0, '0},
    '{'{REQ_LOAD_EMB,  15'd32767, 16'sh5555, 10'd0},    1'b0, '0},
    '{'{REQ_CONTEXT,   15'd0,     16'sh0000, 10'd1023}, 1'b0, '0}
  };

  // Out-of-range register values: zero acts as one, above the top acts as top.
  function automatic int eff_reg(int idx, int top);
    int v;
    v = reg_val[idx];
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic void clear_ngram();
    foreach (unit_acc[h]) unit_acc[h] = 0;
    word_pos = 0;
  endfunction

  function automatic int unsigned sigmoid_q16(longint act);
    longint      mag;
    int          k;
    int unsigned f, p;
    mag = (act < 0) ? -act : act;
    k = int'(mag >> 10);
    if (mag >= 32 * 1024) begin
      p = SIG_PTS[32];
    end else begin
      f = int'(mag & 1023);
      p = SIG_PTS[k] + (((SIG_PTS[k+1] - SIG_PTS[k]) * f + 512) >> 10);
    end
    return (act < 0) ? 65536 - p : p;
  endfunction

  // Advance the predictor by one accepted item; queue any results it causes.
  function automatic void rbm_accept(in_item_t it);
    int        nl, hc, ed, p, wbase;
    longint    a, act;
    out_item_t r;
    case (req_type_t'(it.req_type))
      REQ_LOAD_EMB: begin
        emb_mem[it.table_address] = it.load_value;
        emb_set[it.table_address] = 1'b1;
      end
      REQ_LOAD_WGT: begin
        if (it.table_address < WGT_N) begin
          wgt_mem[it.table_address] = it.load_value;
          wgt_set[it.table_address] = 1'b1;
        end
      end
      REQ_LOAD_BIAS: begin
        if (it.table_address < HIDDEN_MAX) begin
          bias_mem[it.table_address] = it.load_value;
          bias_set[it.table_address] = 1'b1;
        end
      end
      default: begin
        nl = eff_reg(CFG_NGRAM_LEN, NGRAM_MAX);
        hc = eff_reg(CFG_HIDDEN_COUNT, HIDDEN_MAX);
        ed = eff_reg(CFG_EMBED_DIM, DIM_MAX);
        p = (word_pos < NGRAM_MAX) ? word_pos : NGRAM_MAX - 1;
        wbase = int'(it.word_id) * DIM_MAX;
        for (int h = 0; h < hc; h++) begin
          a = unit_acc[h];
          for (int d = 0; d < ed; d++) begin
            a += longint'(emb_mem[wbase + d]) *
                 longint'(wgt_mem[(p * HIDDEN_MAX + h) * DIM_MAX + d]);
            if (a > ACC_TOP) a = ACC_TOP;
            if (a < ACC_BOT) a = ACC_BOT;
          end
          unit_acc[h] = a;
        end
        word_pos++;
        if (word_pos >= nl) begin
          for (int h = 0; h < hc; h++) begin
            act = (longint'(bias_mem[h]) * 4096 + unit_acc[h] + 2048) >>> 12;
            if (act > 8388607) act = 8388607;
            if (act < -8388608) act = -8388608;
            r.hidden_index = h[5:0];
            r.activation   = act[23:0];
            r.probability  = 16'(sigmoid_q16(act));
            r.last_of_run  = (h == hc - 1);
            unit_results = {unit_results, r};
          end
          clear_ngram();
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, in-order compare of every field.
  // --------------------------------------------------------------------------
  // Compare on the falling edge, where the handshake that the next rising
  // edge completes is already stable.
  always @(negedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (unit_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual unit %0d act %0d",
                 $time, out_item.hidden_index, out_item.activation);
      end else begin
        want = unit_results.pop_front();
        if (out_item.hidden_index !== want.hidden_index ||
            out_item.activation !== want.activation ||
            out_item.probability !== want.probability ||
            out_item.last_of_run !== want.last_of_run) begin
          errors++;
          $display("%0t: result mismatch: expected unit %0d act %0d prob %0d last %0d,",
                   $time, want.hidden_index, want.activation, want.probability,
                   want.last_of_run);
          $display("%0t:   actual unit %0d act %0d prob %0d last %0d", $time,
                   out_item.hidden_index, out_item.activation, out_item.probability,
                   out_item.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: a run that never drains ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Offer one item, idle first at random, hold until accepted, then predict.
  // Valid stays high after acceptance so back-to-back items need no gap.
  // Ready is checked on the falling edge, ahead of the accepting rising edge.
  task automatic offer(in_item_t it);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    rbm_accept(it);
  endtask

  // Drop valid, wait until every predicted result has arrived, then let the
  // longest possible word still in flight finish.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (unit_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all three registers on an idle block, one per cycle.
  task automatic set_regs(logic [6:0] nl, logic [6:0] hc, logic [6:0] ed);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_NGRAM_LEN;
    cfg_data <= nl;
    @(posedge clk);
    cfg_index <= CFG_HIDDEN_COUNT;
    cfg_data <= hc;
    @(posedge clk);
    cfg_index <= CFG_EMBED_DIM;
    cfg_data <= ed;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_val[CFG_NGRAM_LEN]    = nl & 7'h0F;
    reg_val[CFG_HIDDEN_COUNT] = hc;
    reg_val[CFG_EMBED_DIM]    = ed & 7'h3F;
    clear_ngram();
  endtask

  function automatic logic [15:0] pick_value();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'($urandom_range(8191)) - 16'd4096;
  endfunction

  function automatic in_item_t load_item(req_type_t t, int addr, logic [15:0] v);
    in_item_t it;
    it.req_type      = t;
    it.table_address = addr[14:0];
    it.load_value    = v;
    it.word_id       = 10'($urandom);
    return it;
  endfunction

  // Send one context word, first loading whatever entries it would read
  // that were never written (embedding, weights of this position, biases).
  task automatic send_word(int word);
    int       nl, hc, ed, p;
    in_item_t it;
    nl = eff_reg(CFG_NGRAM_LEN, NGRAM_MAX);
    hc = eff_reg(CFG_HIDDEN_COUNT, HIDDEN_MAX);
    ed = eff_reg(CFG_EMBED_DIM, DIM_MAX);
    p  = (word_pos < NGRAM_MAX) ? word_pos : NGRAM_MAX - 1;
    for (int d = 0; d < ed; d++)
      if (!emb_set[word * DIM_MAX + d])
        offer(load_item(REQ_LOAD_EMB, word * DIM_MAX + d, pick_value()));
    for (int h = 0; h < hc; h++)
      for (int d = 0; d < ed; d++)
        if (!wgt_set[(p * HIDDEN_MAX + h) * DIM_MAX + d])
          offer(load_item(REQ_LOAD_WGT, (p * HIDDEN_MAX + h) * DIM_MAX + d,
                          pick_value()));
    if (word_pos + 1 >= nl)
      for (int h = 0; h < hc; h++)
        if (!bias_set[h]) offer(load_item(REQ_LOAD_BIAS, h, pick_value()));
    it = load_item(REQ_CONTEXT, $urandom, 16'($urandom));
    it.word_id = word[9:0];
    offer(it);
  endtask

  // Mostly well-formed n-grams over a small vocabulary, with stray loads
  // (in range and out of range) mixed in.
  task automatic random_run(int n);
    int t, addr;
    repeat (n) begin
      if ($urandom_range(99) < 70) begin
        send_word(word_pool[$urandom_range(7)]);
      end else begin
        t = $urandom_range(2);
        case (t)
          0: addr = $urandom_range(1) ? $urandom_range(EMB_N - 1)
                  : word_pool[$urandom_range(7)] * DIM_MAX + $urandom_range(DIM_MAX - 1);
          1: addr = $urandom_range(1) ? $urandom_range(32767)
                  : $urandom_range(WGT_N - 1);
          default: addr = $urandom_range(1) ? $urandom_range(32767)
                        : $urandom_range(HIDDEN_MAX - 1);
        endcase
        offer(load_item(req_type_t'(t), addr, pick_value()));
      end
    end
  endtask

  // Load one word's embedding and unit 0's bias with extremes; with every
  // weight of unit 0 at the most negative value, 32 products push the
  // activation past its limit.
  task automatic saturate_run(logic [15:0] ev, logic [15:0] bv);
    for (int d = 0; d < DIM_MAX; d++)
      offer(load_item(REQ_LOAD_EMB, word_pool[2] * DIM_MAX + d, ev));
    offer(load_item(REQ_LOAD_BIAS, 0, bv));
    send_word(word_pool[2]);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    reg_val[CFG_NGRAM_LEN]    = 7'd4;
    reg_val[CFG_HIDDEN_COUNT] = 7'd64;
    reg_val[CFG_EMBED_DIM]    = 7'd32;
    clear_ngram();
    word_pool[0] = 0;
    word_pool[1] = 1023;
    for (int i = 2; i < 8; i++) word_pool[i] = $urandom_range(1, 1022);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: one word per n-gram, one unit, one dimension.
    set_regs(7'd1, 7'd1, 7'd1);
    foreach (PROBES[i]) begin
      offer(PROBES[i].it);
      if (PROBES[i].fixed) unit_results[unit_results.size() - 1] = PROBES[i].want;
    end

    // Random phases over several register settings, extremes included.
    set_regs(7'd4, 7'd3, 7'd2);
    random_run(40);
    set_regs(7'd0, 7'd127, 7'd0);   // zero acts as one, 127 acts as 64 units
    random_run(20);
    calm = 1'b1;                    // a stretch with no idling on either side
    set_regs(7'd15, 7'd2, 7'd1);    // ngram clamps to 8
    random_run(40);
    calm = 1'b0;

    // Push the activation to both saturation limits.
    set_regs(7'd1, 7'd0, 7'd63);    // zero acts as one unit, dims clamp to 32
    for (int d = 0; d < DIM_MAX; d++) offer(load_item(REQ_LOAD_WGT, d, 16'h8000));
    saturate_run(16'h8000, 16'h7FFF);
    saturate_run(16'h7FFF, 16'h8000);

    set_regs(7'd3, 7'd5, 7'd2);
    random_run(30);

    drain_results();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
